### rtl/mcid_pkg.sv
// Shared types, widths and register indexes for the multi-channel input debouncer.
package mcid_pkg;

	localparam int NUM_CH_MAX = 4;
	localparam int TIMER_W    = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [TIMER_W-1:0] TIMER_MAX  = '1;
	localparam logic [TIMER_W-1:0] HOLD_RESET = TIMER_W'(1);

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_CONNECTED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_BASE = 3'd2;

	// per-lane status toward the merge stage
	typedef struct packed {
		logic stable;     // debounced state before this tick
		logic next_state; // debounced state after this tick
		logic changed;    // flipped on this tick
	} lane_res_t;

	// one result item
	typedef struct packed {
		logic [NUM_CH_MAX-1:0] debounced_states;
		logic [NUM_CH_MAX-1:0] changed_flags;
	} result_t;

endpackage

### rtl/mcid_lane.sv
// One debounce lane: debounced state, mismatch timer, saturating add and hold compare.
module mcid_lane
	import mcid_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [TIMER_W-1:0] tick_delta,
	input  logic               raw_bit,
	input  logic               connected,
	input  logic               invert,
	input  logic [TIMER_W-1:0] hold_time,
	output lane_res_t          res
);

	logic               stable_q;
	logic [TIMER_W-1:0] timer_q;
	logic               level;
	logic               mismatch;
	logic [TIMER_W:0]   sum_full;
	logic [TIMER_W-1:0] sum_sat;
	logic               reached;

	assign level    = connected & (raw_bit ^ invert);
	assign mismatch = level != stable_q;
	assign sum_full = {1'b0, timer_q} + {1'b0, tick_delta};
	assign sum_sat  = sum_full[TIMER_W] ? TIMER_MAX : sum_full[TIMER_W-1:0];
	assign reached  = sum_sat >= hold_time;

	assign res.stable     = stable_q;
	assign res.changed    = mismatch & reached;
	assign res.next_state = (mismatch & reached) ? level : stable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 1'b0;
			timer_q  <= '0;
		end else if (accept) begin
			stable_q <= res.next_state;
			if (mismatch && !reached) begin
				timer_q <= sum_sat;
			end else begin
				timer_q <= '0;
			end
		end
	end

endmodule

### rtl/mcid_merge.sv
// Merge stage: collects lane results into a two-entry output queue (output reg plus skid).
module mcid_merge
	import mcid_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    res_valid,
	input  logic    res_stall,
	output result_t res_data
);

	logic    head_valid_q;
	logic    skid_valid_q;
	result_t head_q;
	result_t skid_q;
	logic    take;

	assign take      = head_valid_q & ~res_stall;
	assign full      = skid_valid_q;
	assign res_valid = head_valid_q;
	assign res_data  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (!push) begin
				head_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!head_valid_q) begin
				head_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) begin
				head_q <= skid_q;
			end else if (push) begin
				head_q <= push_data;
			end
		end else if (push) begin
			if (!head_valid_q) begin
				head_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

### rtl/multi_channel_input_debouncer.sv
// Top level of the multi-channel input debouncer: config regs, lanes, merge queue.
// The result item of an accepted tick is registered into the output queue, behind any item still held.
// Throughput: one tick per cycle while tick_stall is low; each lane does one saturating add and one compare.
// A two-entry output queue lets one more tick in while a result waits; tick_stall
// rises only when both entries hold items.
// Reset (arst_n low, async): states off, timers zero, masks zero, hold times one, queue empty.
module multi_channel_input_debouncer
	import mcid_pkg::*;
#(
	parameter int CHANNELS = NUM_CH_MAX
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// config write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// tick channel
	input  logic                  tick_valid,
	output logic                  tick_stall,
	input  logic [TIMER_W-1:0]    tick_delta,
	input  logic [NUM_CH_MAX-1:0] raw_levels,
	// result channel
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [NUM_CH_MAX-1:0] debounced_states,
	output logic [NUM_CH_MAX-1:0] changed_flags
);

	logic [NUM_CH_MAX-1:0] connected_mask_q;
	logic [NUM_CH_MAX-1:0] invert_mask_q;
	logic [TIMER_W-1:0]    hold_time_q [CHANNELS];

	logic                  accept;
	lane_res_t             lane_res [CHANNELS];
	logic [NUM_CH_MAX-1:0] stable_vec;
	logic [NUM_CH_MAX-1:0] next_vec;
	logic [NUM_CH_MAX-1:0] chg_vec;
	result_t               push_data;
	result_t               res_data;

	assign accept = tick_valid & ~tick_stall;

	// mask registers; bits above the lane count are never read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			connected_mask_q <= '0;
			invert_mask_q    <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_CONNECTED) begin
				connected_mask_q <= cfg_data[NUM_CH_MAX-1:0];
			end
			if (cfg_index == REG_INVERT) begin
				invert_mask_q <= cfg_data[NUM_CH_MAX-1:0];
			end
		end
	end

	// one lane per channel; hold time lives next to its lane
	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hold_time_q[c] <= HOLD_RESET;
			end else if (cfg_we && cfg_index == (REG_HOLD_BASE + CFG_IDX_W'(c))) begin
				hold_time_q[c] <= cfg_data[TIMER_W-1:0];
			end
		end

		mcid_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.accept     (accept),
			.tick_delta (tick_delta),
			.raw_bit    (raw_levels[c]),
			.connected  (connected_mask_q[c]),
			.invert     (invert_mask_q[c]),
			.hold_time  (hold_time_q[c]),
			.res        (lane_res[c])
		);
	end

	// gather lane outputs; unused channels report zero
	always_comb begin
		stable_vec = '0;
		next_vec   = '0;
		chg_vec    = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			stable_vec[c] = lane_res[c].stable;
			next_vec[c]   = lane_res[c].next_state;
			chg_vec[c]    = lane_res[c].changed;
		end
	end

	assign push_data.debounced_states = next_vec;
	assign push_data.changed_flags    = chg_vec;

	mcid_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (push_data),
		.full      (tick_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	assign debounced_states = res_data.debounced_states;
	assign changed_flags    = res_data.changed_flags;

	// a flip reported on a tick shows up in the lane state on the next cycle
	a_flip_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		($past(accept) && $past(arst_n)) |-> (stable_vec == ($past(stable_vec) ^ $past(chg_vec))))
		else $error("lane state does not match reported flips");

	// lanes hold their state between ticks
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(accept) && $past(arst_n)) |-> $stable(stable_vec))
		else $error("lane state moved without a tick");

	// an accepted tick always leaves a result pending
	a_result_pending: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_valid)
		else $error("accepted tick produced no result");

	// a flip only goes toward the new state
	a_flip_target: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ((next_vec & chg_vec) == (~stable_vec & chg_vec)))
		else $error("changed flag set without state flip");

endmodule

### tb/sv/tb_multi_channel_input_debouncer.sv
// Self-checking testbench for the multi-channel input debouncer: tick stimulus, prediction, result checks.
module tb_multi_channel_input_debouncer;
	import mcid_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// register indexes past the last hold time; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(REG_HOLD_BASE + NUM_CH_MAX);
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;
	localparam int                   HOLD_IDX_W    = $clog2(NUM_CH_MAX);

	localparam int QUIET_LIMIT    = 2000; // cycles with no handshake before we give up
	localparam int RX_HOLD_CYCLES = 40;   // long receiver hold-off, fills the output queue
	localparam int PHASE_ITEMS    = 100;

	typedef struct packed {
		logic [TIMER_W-1:0]    dt;
		logic [NUM_CH_MAX-1:0] raw;
	} tick_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  tick_valid = 1'b0;
	logic                  tick_stall;
	logic [TIMER_W-1:0]    tick_delta = '0;
	logic [NUM_CH_MAX-1:0] raw_levels = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b1;
	logic [NUM_CH_MAX-1:0] debounced_states;
	logic [NUM_CH_MAX-1:0] changed_flags;

	multi_channel_input_debouncer u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.tick_valid       (tick_valid),
		.tick_stall       (tick_stall),
		.tick_delta       (tick_delta),
		.raw_levels       (raw_levels),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.debounced_states (debounced_states),
		.changed_flags    (changed_flags)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Predictor state: our own copy of the registers and the lanes
	// ---------------------------------------------------------------
	logic [NUM_CH_MAX-1:0] conn_mask;
	logic [NUM_CH_MAX-1:0] inv_mask;
	logic [TIMER_W-1:0]    hold_time [NUM_CH_MAX];
	logic                  debounced [NUM_CH_MAX];
	logic [TIMER_W-1:0]    bounce_timer [NUM_CH_MAX];

	tick_item_t tick_backlog[$];     // ticks waiting for the driver
	result_t    expected_results[$]; // predicted outputs, oldest first

	int  error_count = 0;
	int  result_count = 0;
	int  tx_idle_max = 5;
	int  rx_idle_max = 5;
	bit  rx_hold_req = 1'b0;
	bit  tick_taken = 1'b0;
	bit  res_taken = 1'b0;
	int  tick_wait = 0;
	int  res_wait = 0;
	int  quiet_cycles = 0;

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// One tick through every lane. A lane whose level disagrees with its
	// debounced state accumulates elapsed time (saturating), and flips once
	// the timer reaches the hold time; agreement clears the timer.
	function automatic result_t debounce_tick(input logic [TIMER_W-1:0] dt,
	                                          input logic [NUM_CH_MAX-1:0] raw);
		result_t          r;
		logic             level;
		logic [TIMER_W:0] sum;
		r = '0;
		for (int c = 0; c < NUM_CH_MAX; c++) begin
			level = conn_mask[c] ? (raw[c] ^ inv_mask[c]) : 1'b0;
			if (level != debounced[c]) begin
				sum = {1'b0, bounce_timer[c]} + {1'b0, dt};
				if (sum > {1'b0, TIMER_MAX})
					sum = {1'b0, TIMER_MAX};
				bounce_timer[c] = sum[TIMER_W-1:0];
				if (bounce_timer[c] >= hold_time[c]) begin
					debounced[c] = level;
					bounce_timer[c] = '0;
					r.changed_flags[c] = 1'b1;
				end
			end else begin
				bounce_timer[c] = '0;
			end
			r.debounced_states[c] = debounced[c];
		end
		return r;
	endfunction

	// Register write: one cycle with cfg_we high, then the model follows.
	// Only called while the block is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_CONNECTED: conn_mask = val[NUM_CH_MAX-1:0];
			REG_INVERT:    inv_mask = val[NUM_CH_MAX-1:0];
			default: begin
				// indexes beyond the hold times are dropped by the block
				if (idx >= REG_HOLD_BASE && idx < REG_UNUSED_LO)
					hold_time[HOLD_IDX_W'(idx - REG_HOLD_BASE)] = val[TIMER_W-1:0];
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_tick(input int dt, input int raw);
		tick_item_t it;
		it.dt = dt[TIMER_W-1:0];
		it.raw = raw[NUM_CH_MAX-1:0];
		tick_backlog.push_back(it);
	endtask

	// Block is idle once nothing is queued, offered or outstanding; every tick
	// yields a result, so an empty prediction queue means every result is out.
	task automatic wait_idle();
		while (tick_backlog.size() != 0 || tick_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	function automatic logic [TIMER_W-1:0] pick_hold();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return HOLD_RESET;
			2:       return TIMER_MAX;
			3:       return TIMER_W'($urandom_range(1, 300));
			default: return TIMER_W'($urandom_range(1, 32767));
		endcase
	endfunction

	// Realistic switch activity: a target level that moves now and then,
	// a short burst of contact bounce after each move, rare stray glitches.
	task automatic queue_bouncy_ticks(input int n, input int dt_max);
		logic [NUM_CH_MAX-1:0] target;
		logic [NUM_CH_MAX-1:0] raw;
		int                    settle;
		int                    dt;
		target = NUM_CH_MAX'($urandom_range(0, 15));
		settle = 0;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				target = NUM_CH_MAX'($urandom_range(0, 15));
				settle = $urandom_range(1, 6);
			end
			raw = target;
			if (settle > 0) begin
				raw ^= NUM_CH_MAX'($urandom_range(0, 15));
				settle--;
			end else if ($urandom_range(0, 29) == 0) begin
				raw = NUM_CH_MAX'($urandom_range(0, 15));
			end
			if ($urandom_range(0, 7) == 0)
				dt = $urandom_range(0, 32767);
			else
				dt = $urandom_range(0, dt_max);
			push_tick(dt, raw);
		end
	endtask

	// ---------------------------------------------------------------
	// Tick driver: offers queued ticks at the falling edge, keeps the
	// payload steady while stalled, waits a drawn gap after each accept.
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		logic       offer;
		tick_item_t it;
		if (arst_n) begin
			offer = tick_valid;
			if (tick_taken) begin
				offer = 1'b0;
				tick_wait = $urandom_range(0, tx_idle_max);
			end
			if (!offer) begin
				if (tick_wait > 0) begin
					tick_wait--;
				end else if (tick_backlog.size() != 0) begin
					it = tick_backlog.pop_front();
					tick_delta <= it.dt;
					raw_levels <= it.raw;
					offer = 1'b1;
				end
			end
			tick_valid <= offer;
		end
	end

	// Result receiver: stalls for a drawn number of cycles per item, or for
	// a long stretch on request so the block backs up into the tick side.
	always @(negedge clk) begin
		if (res_taken)
			res_wait = $urandom_range(0, rx_idle_max);
		if (rx_hold_req) begin
			res_wait = RX_HOLD_CYCLES;
			rx_hold_req = 1'b0;
		end
		if (res_wait > 0) begin
			res_stall <= 1'b1;
			res_wait--;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// Monitor: predicts on every accepted tick, checks every accepted
	// result against the oldest prediction.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		result_t want;
		tick_taken = 1'b0;
		res_taken = 1'b0;
		if (arst_n) begin
			if (tick_valid && !tick_stall) begin
				expected_results.push_back(debounce_tick(tick_delta, raw_levels));
				tick_taken = 1'b1;
			end
			if (res_valid && !res_stall) begin
				res_taken = 1'b1;
				if (expected_results.size() == 0) begin
					flag_error($sformatf("unexpected result states=%h changed=%h",
						debounced_states, changed_flags));
				end else begin
					want = expected_results.pop_front();
					if (debounced_states !== want.debounced_states)
						flag_error($sformatf("result %0d: debounced_states %h, want %h",
							result_count, debounced_states, want.debounced_states));
					if (changed_flags !== want.changed_flags)
						flag_error($sformatf("result %0d: changed_flags %h, want %h",
							result_count, changed_flags, want.changed_flags));
				end
				result_count++;
			end
		end
	end

	// Watchdog: any handshake resets the count.
	always @(posedge clk) begin
		if (!arst_n || (tick_valid && !tick_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// Sequence: reset, directed ticks, then randomized phases
	// ---------------------------------------------------------------
	initial begin
		logic [TIMER_W-1:0] h [NUM_CH_MAX];
		int                 dt_max;

		conn_mask = '0;
		inv_mask = '0;
		for (int c = 0; c < NUM_CH_MAX; c++) begin
			hold_time[c] = HOLD_RESET;
			debounced[c] = 1'b0;
			bounce_timer[c] = '0;
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset config: nothing connected, so every channel stays off
		push_tick(32767, 15);
		push_tick(0, 0);
		wait_idle();

		// all connected (upper data bits must be dropped), hold times at the
		// corners: zero flips on the first mismatch even with no elapsed time,
		// full scale is reached by one full-scale step and through saturation
		write_reg(REG_CONNECTED, '1);
		write_reg(REG_INVERT, 15'h7FF0);
		write_reg(REG_HOLD_BASE, '0);
		write_reg(CFG_IDX_W'(REG_HOLD_BASE + 1), HOLD_RESET);
		write_reg(CFG_IDX_W'(REG_HOLD_BASE + 2), TIMER_MAX);
		write_reg(CFG_IDX_W'(REG_HOLD_BASE + 3), 15'd100);
		write_reg(REG_UNUSED_LO, 15'h5555);
		write_reg(REG_UNUSED_HI, 15'h2AAA);
		push_tick(0, 15);
		push_tick(32767, 15);
		push_tick(20000, 0);
		push_tick(20000, 0);
		push_tick(60, 8);
		push_tick(0, 0);      // agreement clears the ch3 timer
		push_tick(60, 8);     // so this does not reach 100
		push_tick(60, 8);
		push_tick(1, 5);
		push_tick(1, 10);
		push_tick(16384, 10);
		wait_idle();

		// mask change between runs: inverted, odd channels unplugged
		write_reg(REG_INVERT, 15'h000F);
		write_reg(REG_CONNECTED, 15'h0005);
		push_tick(0, 0);
		push_tick(40, 0);
		push_tick(100, 15);
		push_tick(32767, 0);
		push_tick(32767, 15);
		push_tick(7, 10);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			tx_idle_max = 5;
			rx_idle_max = 5;
			case (p)
				0: begin // shortest hold everywhere
					for (int c = 0; c < NUM_CH_MAX; c++) h[c] = HOLD_RESET;
					write_reg(REG_CONNECTED, '1);
					write_reg(REG_INVERT, '0);
					dt_max = 3;
				end
				1: begin // longest hold everywhere, all inverted
					for (int c = 0; c < NUM_CH_MAX; c++) h[c] = TIMER_MAX;
					write_reg(REG_CONNECTED, '1);
					write_reg(REG_INVERT, '1);
					dt_max = 12000;
				end
				2: begin // back-to-back on both sides
					for (int c = 0; c < NUM_CH_MAX; c++) h[c] = TIMER_W'($urandom_range(1, 2000));
					write_reg(REG_CONNECTED, CFG_DATA_W'($urandom_range(0, 15)));
					write_reg(REG_INVERT, CFG_DATA_W'($urandom_range(0, 15)));
					tx_idle_max = 0;
					rx_idle_max = 0;
					dt_max = 600;
				end
				default: begin
					for (int c = 0; c < NUM_CH_MAX; c++) h[c] = pick_hold();
					write_reg(REG_CONNECTED, CFG_DATA_W'($urandom_range(0, 32767)));
					write_reg(REG_INVERT, CFG_DATA_W'($urandom_range(0, 32767)));
					if (p == 3) begin
						// sender never idles while the receiver holds off
						tx_idle_max = 0;
						@(posedge clk);
						rx_hold_req = 1'b1;
					end
					if (p == 5)
						write_reg(REG_UNUSED_LO, CFG_DATA_W'($urandom_range(0, 32767)));
					dt_max = 400;
				end
			endcase
			for (int c = 0; c < NUM_CH_MAX; c++)
				write_reg(CFG_IDX_W'(REG_HOLD_BASE + c), h[c]);
			queue_bouncy_ticks(PHASE_ITEMS, dt_max);
			wait_idle();
		end

		repeat (5) @(posedge clk);
		if (expected_results.size() != 0)
			flag_error($sformatf("%0d results never arrived", expected_results.size()));
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
